/* design/dtm_pkg.sv */
// shared types, constants and codes for the differential thrust mixer
`timescale 1ns / 1ps

package dtm_pkg;

	// field widths
	localparam int ARG_W    = 12;
	localparam int PULSE_W  = 11;
	localparam int PCT_W    = 8;
	localparam int MOD_W    = 9;
	localparam int THRUST_W = 8;
	localparam int MODE_W   = 4;

	// apb port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// divider: 16-bit dividend, modifier-sized divisor
	localparam int DIV_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// signed width of the mixing arithmetic
	localparam int MIX_W = 18;

	// pulse and range limits
	localparam int PULSE_MIN  = 1000;
	localparam int PULSE_MAX  = 2000;
	localparam int PULSE_MID  = 1500;
	localparam int PCT_LIM    = 100;
	localparam int LIFT_LIM   = 400;
	localparam int POWER_SPAN = 500;

	// divide by five as multiply and shift, exact for magnitudes up to 1047
	localparam int THRUST_RECIP = 1639;
	localparam int THRUST_SHIFT = 13;

	// register reset values
	localparam int FWD_MOD_RST  = 100;
	localparam int REV_MOD_RST  = 100;
	localparam int MIDPOINT_RST = 1500;

	typedef enum logic [MODE_W-1:0] {
		MODE_GO   = 4'd0,
		MODE_PORT = 4'd1,
		MODE_VERT = 4'd2,
		MODE_STBD = 4'd3,
		MODE_THRO = 4'd4,
		MODE_YAW  = 4'd5,
		MODE_LIFT = 4'd6,
		MODE_STOP = 4'd7,
		MODE_TICK = 4'd8
	} mode_t;

	typedef enum logic [1:0] {
		REG_FWD_MOD  = 2'd0,
		REG_REV_MOD  = 2'd1,
		REG_MIDPOINT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_MIX_GO,
		ST_MIX_WAIT,
		ST_MIX_FIN,
		ST_THR_MUL,
		ST_THR_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MOD_W-1:0]   fwd_mod;
		logic [MOD_W-1:0]   rev_mod;
		logic [PULSE_W-1:0] midpoint;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [MOD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [MOD_W-1:0] remainder;
	} div_rsp_t;

endpackage

/* design/dtm_div.sv */
// restoring divider, one quotient bit per cycle, used for the power scaling
`timescale 1ns / 1ps

module dtm_div
	import dtm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [MOD_W-1:0]     rem_q;
	logic [MOD_W-1:0]     den_q;

	logic [MOD_W:0]       trial;
	logic                 ge;
	logic [MOD_W:0]       diff;

	// one trial subtract per cycle
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// quotient and remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

/* design/dtm_regs.sv */
// apb configuration registers: modifiers and stop midpoint
`timescale 1ns / 1ps

module dtm_regs
	import dtm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [MOD_W-1:0]   fwd_mod_q;
	logic [MOD_W-1:0]   rev_mod_q;
	logic [PULSE_W-1:0] midpoint_q;
	logic               wr_en;
	logic [1:0]         idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_mod_q  <= MOD_W'(FWD_MOD_RST);
			rev_mod_q  <= MOD_W'(REV_MOD_RST);
			midpoint_q <= PULSE_W'(MIDPOINT_RST);
		end else if (wr_en) begin
			unique case (idx)
				REG_FWD_MOD:  fwd_mod_q  <= pwdata[MOD_W-1:0];
				REG_REV_MOD:  rev_mod_q  <= pwdata[MOD_W-1:0];
				REG_MIDPOINT: midpoint_q <= pwdata[PULSE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_FWD_MOD:  prdata = APB_DW'(fwd_mod_q);
			REG_REV_MOD:  prdata = APB_DW'(rev_mod_q);
			REG_MIDPOINT: prdata = APB_DW'(midpoint_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.fwd_mod  = fwd_mod_q;
	assign cfg.rev_mod  = rev_mod_q;
	assign cfg.midpoint = midpoint_q;

endmodule

/* design/differential_thrust_mixer_core.sv */
// top level: command decode, mixing sequencer and result register
//
// channel | handshake             | payload
// --------+-----------------------+---------------------------------------------
// in      | in_valid / in_ready   | mode, arg_first, arg_second, arg_third
// out     | out_valid / out_ready | port_out, vertical_out, starboard_out,
//         |                       | outputs_changed, forward_thrust_pct, accepted
// cfg     | apb psel/penable      | paddr, pwdata, prdata
//
// throttle and yaw items take longer from acceptance to the next acceptance than all
// other items; the divider for the power scaling sets the longer path, the thrust
// percentage takes a multiply state and a clamp state. in_ready is high only while the
// sequencer is idle. a finished result waits in the output register; the next item is
// taken meanwhile, and its result waits in the last state until the register frees.
// reset puts the target and applied pulses at 1500, throttle and yaw at zero,
// registers at defaults.
`timescale 1ns / 1ps

module differential_thrust_mixer_core
	import dtm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// command items
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [ARG_W-1:0]    arg_first,
	input  logic signed [ARG_W-1:0]    arg_second,
	input  logic signed [ARG_W-1:0]    arg_third,
	// result items
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PULSE_W-1:0]         port_out,
	output logic [PULSE_W-1:0]         vertical_out,
	output logic [PULSE_W-1:0]         starboard_out,
	output logic                       outputs_changed,
	output logic signed [THRUST_W-1:0] forward_thrust_pct,
	output logic                       accepted,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_AW-1:0]          paddr,
	input  logic [APB_DW-1:0]          pwdata,
	output logic [APB_DW-1:0]          prdata,
	output logic                       pready
);

	localparam logic signed [MIX_W-1:0] MIX_MID = MIX_W'(PULSE_MID);
	localparam logic signed [MIX_W-1:0] MIX_MAX = MIX_W'(PULSE_MAX);
	localparam logic signed [MIX_W-1:0] MIX_MIN = MIX_W'(PULSE_MIN);
	localparam logic signed [12:0]      THR_ZERO = 13'(PULSE_MIN);
	localparam logic signed [10:0]      THR_LIM  = 11'(PCT_LIM);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q, state_d;

	// captured item
	logic [MODE_W-1:0]        mode_q;
	logic signed [ARG_W-1:0]  a_q, b_q, c_q;

	// mixer state
	logic [PULSE_W-1:0]       port_t_q, vert_t_q, stbd_t_q;
	logic [PULSE_W-1:0]       port_a_q, vert_a_q, stbd_a_q;
	logic signed [PCT_W-1:0]  thr_q, yaw_q;
	logic signed [MIX_W-1:0]  power_q;
	logic signed [THRUST_W-1:0] thrust_q;
	logic                     acc_q, chg_q;

	// result register
	logic                     out_valid_q;
	logic [PULSE_W-1:0]       port_o_q, vert_o_q, stbd_o_q;
	logic                     chg_o_q, acc_o_q;
	logic signed [THRUST_W-1:0] thrust_o_q;

	logic                     in_take, out_load;

	// range checks on the captured arguments
	logic a_pulse, b_pulse, c_pulse, a_pct, a_lift;
	always_comb begin
		a_pulse = int'(a_q) >= PULSE_MIN && int'(a_q) <= PULSE_MAX;
		b_pulse = int'(b_q) >= PULSE_MIN && int'(b_q) <= PULSE_MAX;
		c_pulse = int'(c_q) >= PULSE_MIN && int'(c_q) <= PULSE_MAX;
		a_pct   = int'(a_q) >= -PCT_LIM && int'(a_q) <= PCT_LIM;
		a_lift  = int'(a_q) >= -LIFT_LIM && int'(a_q) <= LIFT_LIM;
	end

	// power scaling operands
	logic [6:0]       thr_abs;
	logic [DIV_W-1:0] pow_num;
	logic [MOD_W-1:0] pow_mod_raw, pow_mod;
	always_comb begin
		thr_abs     = thr_q[PCT_W-1] ? 7'(-thr_q) : thr_q[6:0];
		pow_num     = DIV_W'(thr_abs) * DIV_W'(POWER_SPAN);
		pow_mod_raw = thr_q[PCT_W-1] ? cfg.rev_mod : cfg.fwd_mod;
		pow_mod     = (pow_mod_raw == '0) ? MOD_W'(1) : pow_mod_raw;
	end

	// power from the quotient, floor for negative throttle
	logic signed [MIX_W-1:0] quo_s, power_d;
	always_comb begin
		quo_s   = $signed({2'b00, div_rsp.quotient});
		power_d = thr_q[PCT_W-1]
			? MIX_MID - quo_s - MIX_W'(div_rsp.remainder != '0)
			: MIX_MID + quo_s;
	end

	// turn and offset
	logic [6:0]              yaw_abs;
	logic [8:0]              aturn;
	logic signed [MIX_W-1:0] aturn_s, turn_s, ov, off, port_m, stbd_m;
	always_comb begin
		yaw_abs = yaw_q[PCT_W-1] ? 7'(-yaw_q) : yaw_q[6:0];
		aturn   = 9'((10'(yaw_abs) * 10'd5) >> 1);
		aturn_s = $signed({9'd0, aturn});
		turn_s  = yaw_q[PCT_W-1] ? -aturn_s : aturn_s;
		if (thr_q[PCT_W-1]) begin
			ov = MIX_MIN - power_q + aturn_s;
		end else begin
			ov = aturn_s + power_q - MIX_MAX;
		end
		off = ov[MIX_W-1] ? '0 : ov;
		if (thr_q[PCT_W-1]) begin
			port_m = power_q + turn_s + off;
			stbd_m = power_q - turn_s + off;
		end else begin
			port_m = power_q + turn_s - off;
			stbd_m = power_q - turn_s - off;
		end
	end

	// thrust from the applied pulses, divide by five as a reciprocal multiply
	logic [PULSE_W:0]        pulse_sum;
	logic signed [12:0]      mean_d;
	logic                    mean_neg;
	logic [PULSE_W-1:0]      mean_abs;
	logic [21:0]             thr_prod;
	logic [8:0]              tmag_q;
	logic                    mean_neg_q;
	logic signed [10:0]      tq, traw;
	logic signed [THRUST_W-1:0] thrust_d;
	always_comb begin
		pulse_sum = {1'b0, port_a_q} + {1'b0, stbd_a_q};
		mean_d    = $signed({2'b00, pulse_sum[PULSE_W:1]}) - THR_ZERO;
		mean_neg  = mean_d[12];
		mean_abs  = mean_neg ? 11'(-mean_d) : mean_d[10:0];
		thr_prod  = 22'(mean_abs) * 22'(THRUST_RECIP);
		tq        = $signed({2'b00, tmag_q});
		traw      = (mean_neg_q ? -tq : tq) - THR_LIM;
		if (traw > THR_LIM) begin
			thrust_d = THRUST_W'(PCT_LIM);
		end else if (traw < -THR_LIM) begin
			thrust_d = THRUST_W'(-PCT_LIM);
		end else begin
			thrust_d = traw[THRUST_W-1:0];
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and divider launches
	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = pow_num;
		div_req.divisor  = pow_mod;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (mode_q == MODE_THRO || mode_q == MODE_YAW) begin
					state_d = ST_MIX_GO;
				end else begin
					state_d = ST_THR_MUL;
				end
			end
			ST_MIX_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_MIX_WAIT;
			end
			ST_MIX_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MIX_FIN;
				end
			end
			ST_MIX_FIN: begin
				state_d = ST_THR_MUL;
			end
			ST_THR_MUL: begin
				state_d = ST_THR_FIN;
			end
			ST_THR_FIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_take = in_ready && in_valid;

	// item capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q <= mode;
			a_q    <= arg_first;
			b_q    <= arg_second;
			c_q    <= arg_third;
		end
	end

	// command execution and mixing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_t_q <= PULSE_W'(PULSE_MID);
			vert_t_q <= PULSE_W'(PULSE_MID);
			stbd_t_q <= PULSE_W'(PULSE_MID);
			port_a_q <= PULSE_W'(PULSE_MID);
			vert_a_q <= PULSE_W'(PULSE_MID);
			stbd_a_q <= PULSE_W'(PULSE_MID);
			thr_q    <= '0;
			yaw_q    <= '0;
			acc_q    <= 1'b0;
			chg_q    <= 1'b0;
		end else if (state_q == ST_APPLY) begin
			acc_q <= 1'b0;
			chg_q <= 1'b0;
			unique case (mode_q)
				MODE_GO: begin
					if (a_pulse && b_pulse && c_pulse) begin
						port_t_q <= a_q[PULSE_W-1:0];
						vert_t_q <= b_q[PULSE_W-1:0];
						stbd_t_q <= c_q[PULSE_W-1:0];
						acc_q    <= 1'b1;
					end
				end
				MODE_PORT: begin
					if (a_pulse) begin
						port_t_q <= a_q[PULSE_W-1:0];
						acc_q    <= 1'b1;
					end
				end
				MODE_VERT: begin
					if (a_pulse) begin
						vert_t_q <= a_q[PULSE_W-1:0];
						acc_q    <= 1'b1;
					end
				end
				MODE_STBD: begin
					if (a_pulse) begin
						stbd_t_q <= a_q[PULSE_W-1:0];
						acc_q    <= 1'b1;
					end
				end
				MODE_THRO: begin
					if (a_pct) begin
						thr_q <= a_q[PCT_W-1:0];
						acc_q <= 1'b1;
					end
				end
				MODE_YAW: begin
					if (a_pct) begin
						yaw_q <= a_q[PCT_W-1:0];
						acc_q <= 1'b1;
					end
				end
				MODE_LIFT: begin
					if (a_lift) begin
						vert_t_q <= PULSE_W'(ARG_W'(PULSE_MID) + a_q);
						acc_q    <= 1'b1;
					end
				end
				MODE_STOP: begin
					port_t_q <= cfg.midpoint;
					vert_t_q <= cfg.midpoint;
					stbd_t_q <= cfg.midpoint;
					acc_q    <= 1'b1;
				end
				MODE_TICK: begin
					acc_q <= 1'b1;
					if (port_t_q != port_a_q || vert_t_q != vert_a_q
						|| stbd_t_q != stbd_a_q) begin
						port_a_q <= port_t_q;
						vert_a_q <= vert_t_q;
						stbd_a_q <= stbd_t_q;
						chg_q    <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_MIX_FIN) begin
			port_t_q <= port_m[PULSE_W-1:0];
			stbd_t_q <= stbd_m[PULSE_W-1:0];
		end
	end

	// power from the divider, thrust over the multiply and clamp states
	always_ff @(posedge clk) begin
		if (state_q == ST_MIX_WAIT && div_rsp.done) begin
			power_q <= power_d;
		end
		if (state_q == ST_THR_MUL) begin
			tmag_q     <= thr_prod[THRUST_SHIFT +: 9];
			mean_neg_q <= mean_neg;
		end
		if (state_q == ST_THR_FIN) begin
			thrust_q <= thrust_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			port_o_q   <= port_a_q;
			vert_o_q   <= vert_a_q;
			stbd_o_q   <= stbd_a_q;
			chg_o_q    <= chg_q;
			acc_o_q    <= acc_q;
			thrust_o_q <= thrust_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign port_out           = port_o_q;
	assign vertical_out       = vert_o_q;
	assign starboard_out      = stbd_o_q;
	assign outputs_changed    = chg_o_q;
	assign accepted           = acc_o_q;
	assign forward_thrust_pct = thrust_o_q;

	dtm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

/* design/dtm_checker.sv */
// port-level checks for the mixer core, bound to the top level
`timescale 1ns / 1ps

module dtm_checker
	import dtm_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [PULSE_W-1:0]         port_out,
	input logic                       outputs_changed,
	input logic signed [THRUST_W-1:0] forward_thrust_pct,
	input logic                       accepted
);

	// one item at a time: ready drops right after an item is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an item was taken");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(port_out))
		else $error("result changed or dropped while stalled");

	// an update of the applied pulses only comes from a tick, which is always accepted
	a_changed_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outputs_changed |-> accepted)
		else $error("outputs_changed without accepted");

	// thrust stays within its percent range
	a_thrust_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (forward_thrust_pct >= -8'sd100 && forward_thrust_pct <= 8'sd100))
		else $error("forward_thrust_pct out of range");

endmodule

bind differential_thrust_mixer_core dtm_checker u_dtm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.port_out           (port_out),
	.outputs_changed    (outputs_changed),
	.forward_thrust_pct (forward_thrust_pct),
	.accepted           (accepted)
);

/* sim/testbench.sv */
// self-checking testbench for the differential thrust mixer core
`timescale 1ns / 1ps

module testbench;
	import dtm_pkg::*;

	// mode codes the block does not decode
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic signed [ARG_W-1:0] a1;
		logic signed [ARG_W-1:0] a2;
		logic signed [ARG_W-1:0] a3;
	} cmd_t;

	typedef struct packed {
		logic [PULSE_W-1:0]        port;
		logic [PULSE_W-1:0]        vert;
		logic [PULSE_W-1:0]        stbd;
		logic                      changed;
		logic signed [THRUST_W-1:0] thrust;
		logic                      acc;
	} readout_t;

	typedef struct packed {
		logic [MODE_W-1:0]          mode;
		logic signed [ARG_W-1:0]    a1;
		logic signed [ARG_W-1:0]    a2;
		logic signed [ARG_W-1:0]    a3;
		logic                       typed;
		logic [PULSE_W-1:0]         e_port;
		logic [PULSE_W-1:0]         e_vert;
		logic [PULSE_W-1:0]         e_stbd;
		logic                       e_chg;
		logic signed [THRUST_W-1:0] e_thr;
		logic                       e_acc;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = '0;
	logic signed [ARG_W-1:0] arg_first = '0;
	logic signed [ARG_W-1:0] arg_second = '0;
	logic signed [ARG_W-1:0] arg_third = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PULSE_W-1:0] port_out;
	logic [PULSE_W-1:0] vertical_out;
	logic [PULSE_W-1:0] starboard_out;
	logic outputs_changed;
	logic signed [THRUST_W-1:0] forward_thrust_pct;
	logic accepted;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// mirror of the block: registers, targets, stored percentages, applied pulses
	int cfg_fwd, cfg_rev, cfg_mid;
	int tgt_port, tgt_vert, tgt_stbd;
	int thr_pct, yaw_pct;
	int app_port, app_vert, app_stbd;

	readout_t readout_q [$];
	int err_count = 0;
	int sent_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_cycle = 0;

	// register settings per random phase, extremes included
	int fwd_settings [6] = '{50, 400, 0, 511, 137, 100};
	int rev_settings [6] = '{400, 50, 0, 1, 250, 100};
	int mid_settings [6] = '{1000, 2000, 0, 2047, 999, 1500};

	// directed items: extremes, every mode, rejections, unknown modes
	dir_row_t directed_steps [0:24] = '{
		'{MODE_TICK, 0, 0, 0, 1'b1, 1500, 1500, 1500, 1'b0, 0, 1'b1},
		'{MODE_GO, 1000, 2000, 1000, 1'b1, 1500, 1500, 1500, 1'b0, 0, 1'b1},
		'{MODE_TICK, 0, 0, 0, 1'b1, 1000, 2000, 1000, 1'b1, -100, 1'b1},
		'{MODE_GO, 2000, 1000, 2000, 1'b1, 1000, 2000, 1000, 1'b0, -100, 1'b1},
		'{MODE_TICK, 0, 0, 0, 1'b1, 2000, 1000, 2000, 1'b1, 100, 1'b1},
		'{MODE_GO, 999, 1500, 1500, 1'b1, 2000, 1000, 2000, 1'b0, 100, 1'b0},
		'{MODE_GO, 1500, 2001, 1500, 1'b1, 2000, 1000, 2000, 1'b0, 100, 1'b0},
		'{MODE_PORT, -2048, 0, 0, 1'b1, 2000, 1000, 2000, 1'b0, 100, 1'b0},
		'{MODE_PORT, 2047, -1, -1, 1'b1, 2000, 1000, 2000, 1'b0, 100, 1'b0},
		'{MODE_VERT, 1000, 0, 0, 1'b1, 2000, 1000, 2000, 1'b0, 100, 1'b1},
		'{MODE_STBD, 2000, 0, 0, 1'b1, 2000, 1000, 2000, 1'b0, 100, 1'b1},
		'{MODE_THRO, 100, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_YAW, -100, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_THRO, -100, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_YAW, 101, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_THRO, -101, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_LIFT, 400, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_LIFT, -401, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_LIFT, -400, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_STOP, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_UNUSED_LO, -2048, 2047, -2048, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
		'{MODE_UNUSED_HI, 1500, 1500, 1500, 1'b0, 0, 0, 0, 1'b0, 0, 1'b0}
	};

	differential_thrust_mixer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.arg_first(arg_first),
		.arg_second(arg_second),
		.arg_third(arg_third),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.port_out(port_out),
		.vertical_out(vertical_out),
		.starboard_out(starboard_out),
		.outputs_changed(outputs_changed),
		.forward_thrust_pct(forward_thrust_pct),
		.accepted(accepted),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one line per mismatch
	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		err_count++;
	endtask

	function automatic bit in_pulse(input int v);
		return v >= PULSE_MIN && v <= PULSE_MAX;
	endfunction

	// throttle and yaw mixing into port and starboard targets
	task automatic remix_targets();
		int m, n, pwr, trn, atrn, ofs;
		m = (thr_pct >= 0) ? cfg_fwd : cfg_rev;
		if (m < 1)
			m = 1;
		n = POWER_SPAN * thr_pct;
		pwr = n / m;
		if (n < 0 && (n % m) != 0)
			pwr = pwr - 1;
		pwr = PULSE_MID + pwr;
		trn = (5 * yaw_pct) / 2;
		atrn = (trn < 0) ? -trn : trn;
		if (thr_pct >= 0) begin
			ofs = atrn + pwr - PULSE_MAX;
			if (ofs < 0)
				ofs = 0;
			tgt_port = pwr + trn - ofs;
			tgt_stbd = pwr - trn - ofs;
		end else begin
			ofs = PULSE_MIN - (pwr - atrn);
			if (ofs < 0)
				ofs = 0;
			tgt_port = pwr + trn + ofs;
			tgt_stbd = pwr - trn + ofs;
		end
	endtask

	// advance the mirror by one command and form the readout it yields
	task automatic predict_mixer_readout(input cmd_t c, output readout_t r);
		int a, b, d, mean, thr;
		logic acc, chg;
		a = int'(c.a1);
		b = int'(c.a2);
		d = int'(c.a3);
		acc = 1'b0;
		chg = 1'b0;
		case (c.mode)
			MODE_GO: begin
				if (in_pulse(a) && in_pulse(b) && in_pulse(d)) begin
					tgt_port = a;
					tgt_vert = b;
					tgt_stbd = d;
					acc = 1'b1;
				end
			end
			MODE_PORT: begin
				if (in_pulse(a)) begin
					tgt_port = a;
					acc = 1'b1;
				end
			end
			MODE_VERT: begin
				if (in_pulse(a)) begin
					tgt_vert = a;
					acc = 1'b1;
				end
			end
			MODE_STBD: begin
				if (in_pulse(a)) begin
					tgt_stbd = a;
					acc = 1'b1;
				end
			end
			MODE_THRO: begin
				if (a >= -PCT_LIM && a <= PCT_LIM) begin
					thr_pct = a;
					acc = 1'b1;
				end
				remix_targets();
			end
			MODE_YAW: begin
				if (a >= -PCT_LIM && a <= PCT_LIM) begin
					yaw_pct = a;
					acc = 1'b1;
				end
				remix_targets();
			end
			MODE_LIFT: begin
				// lift works from the fixed 1500, not the midpoint register
				if (a >= -LIFT_LIM && a <= LIFT_LIM) begin
					tgt_vert = PULSE_MID + a;
					acc = 1'b1;
				end
			end
			MODE_STOP: begin
				tgt_port = cfg_mid;
				tgt_vert = cfg_mid;
				tgt_stbd = cfg_mid;
				acc = 1'b1;
			end
			MODE_TICK: begin
				acc = 1'b1;
				if (tgt_port != app_port || tgt_vert != app_vert || tgt_stbd != app_stbd) begin
					app_port = tgt_port;
					app_vert = tgt_vert;
					app_stbd = tgt_stbd;
					chg = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// forward thrust from the mean of the applied side pulses
		mean = (app_port + app_stbd) / 2;
		thr = (mean - PULSE_MIN) * 200 / 1000 - PCT_LIM;
		if (thr > PCT_LIM)
			thr = PCT_LIM;
		if (thr < -PCT_LIM)
			thr = -PCT_LIM;
		r.port = app_port[PULSE_W-1:0];
		r.vert = app_vert[PULSE_W-1:0];
		r.stbd = app_stbd[PULSE_W-1:0];
		r.changed = chg;
		r.thrust = thr[THRUST_W-1:0];
		r.acc = acc;
	endtask

	// apb write: setup then access, with the bus idle afterwards
	task automatic apb_write(input reg_idx_t idx, input int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(idx));
		pwdata <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input reg_idx_t idx, output logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_AW'(4 * int'(idx));
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// read back all registers against the mirrored values
	task automatic verify_registers();
		logic [APB_DW-1:0] rd;
		apb_read(REG_FWD_MOD, rd);
		if (rd[MOD_W-1:0] !== MOD_W'(cfg_fwd))
			flag_mismatch("forward_modifier_pct readback", int'(rd[MOD_W-1:0]), cfg_fwd);
		apb_read(REG_REV_MOD, rd);
		if (rd[MOD_W-1:0] !== MOD_W'(cfg_rev))
			flag_mismatch("reverse_modifier_pct readback", int'(rd[MOD_W-1:0]), cfg_rev);
		apb_read(REG_MIDPOINT, rd);
		if (rd[PULSE_W-1:0] !== PULSE_W'(cfg_mid))
			flag_mismatch("midpoint_us readback", int'(rd[PULSE_W-1:0]), cfg_mid);
	endtask

	task automatic program_mixer(input int fwd, input int rev, input int mid);
		apb_write(REG_FWD_MOD, fwd);
		apb_write(REG_REV_MOD, rev);
		apb_write(REG_MIDPOINT, mid);
		cfg_fwd = fwd & ((1 << MOD_W) - 1);
		cfg_rev = rev & ((1 << MOD_W) - 1);
		cfg_mid = mid & ((1 << PULSE_W) - 1);
		verify_registers();
	endtask

	// present one command; valid stays high after acceptance unless the next one idles
	task automatic issue_command(input cmd_t c, input bit has_typed, input readout_t typed_r);
		readout_t r;
		while ((sent_count % 64) >= 12 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= c.mode;
		arg_first <= c.a1;
		arg_second <= c.a2;
		arg_third <= c.a3;
		do @(posedge clk); while (!in_ready);
		predict_mixer_readout(c, r);
		readout_q.push_back(has_typed ? typed_r : r);
		sent_count++;
	endtask

	// stop sending and let every owed readout come back
	task automatic drain_readouts();
		in_valid <= 1'b0;
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly in range, some at the bounds, some anything the field holds
	function automatic logic signed [ARG_W-1:0] draw_arg(input int lo, input int hi);
		int pick;
		pick = $urandom_range(99);
		if (pick < 75)
			return ARG_W'(int'($urandom_range(hi - lo)) + lo);
		if (pick < 90) begin
			case ($urandom_range(3))
				0: return ARG_W'(lo - 1);
				1: return ARG_W'(lo);
				2: return ARG_W'(hi);
				default: return ARG_W'(hi + 1);
			endcase
		end
		return ARG_W'($urandom());
	endfunction

	function automatic cmd_t draw_command();
		cmd_t c;
		int pick;
		pick = $urandom_range(99);
		c.a1 = ARG_W'($urandom());
		c.a2 = ARG_W'($urandom());
		c.a3 = ARG_W'($urandom());
		if (pick < 22) begin
			c.mode = MODE_TICK;
		end else if (pick < 38) begin
			c.mode = MODE_THRO;
			c.a1 = draw_arg(-PCT_LIM, PCT_LIM);
		end else if (pick < 54) begin
			c.mode = MODE_YAW;
			c.a1 = draw_arg(-PCT_LIM, PCT_LIM);
		end else if (pick < 64) begin
			c.mode = MODE_GO;
			c.a1 = draw_arg(PULSE_MIN, PULSE_MAX);
			c.a2 = draw_arg(PULSE_MIN, PULSE_MAX);
			c.a3 = draw_arg(PULSE_MIN, PULSE_MAX);
		end else if (pick < 69) begin
			c.mode = MODE_PORT;
			c.a1 = draw_arg(PULSE_MIN, PULSE_MAX);
		end else if (pick < 74) begin
			c.mode = MODE_VERT;
			c.a1 = draw_arg(PULSE_MIN, PULSE_MAX);
		end else if (pick < 79) begin
			c.mode = MODE_STBD;
			c.a1 = draw_arg(PULSE_MIN, PULSE_MAX);
		end else if (pick < 88) begin
			c.mode = MODE_LIFT;
			c.a1 = draw_arg(-LIFT_LIM, LIFT_LIM);
		end else if (pick < 94) begin
			c.mode = MODE_STOP;
		end else begin
			c.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
		end
		return c;
	endfunction

	// result side stall, with stretches of no stall
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		out_ready <= ((rx_cycle % 256) < 40) || ($urandom_range(99) >= rx_idle_pct);
	end

	// compare each result item with the oldest owed readout
	always @(posedge clk) begin
		readout_t want;
		if (arst_n && out_valid && out_ready) begin
			if (readout_q.size() == 0) begin
				flag_mismatch("result item with nothing owed", 1, 0);
			end else begin
				want = readout_q.pop_front();
				if (port_out !== want.port)
					flag_mismatch("port_out", int'(port_out), int'(want.port));
				if (vertical_out !== want.vert)
					flag_mismatch("vertical_out", int'(vertical_out), int'(want.vert));
				if (starboard_out !== want.stbd)
					flag_mismatch("starboard_out", int'(starboard_out), int'(want.stbd));
				if (outputs_changed !== want.changed)
					flag_mismatch("outputs_changed", int'(outputs_changed), int'(want.changed));
				if (forward_thrust_pct !== want.thrust)
					flag_mismatch("forward_thrust_pct", int'(forward_thrust_pct),
						int'(want.thrust));
				if (accepted !== want.acc)
					flag_mismatch("accepted", int'(accepted), int'(want.acc));
			end
		end
	end

	// run limit
	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		dir_row_t row;
		cmd_t c;
		readout_t typed_r;
		readout_t none;
		// mirror reset state
		cfg_fwd = FWD_MOD_RST;
		cfg_rev = REV_MOD_RST;
		cfg_mid = MIDPOINT_RST;
		tgt_port = PULSE_MID;
		tgt_vert = PULSE_MID;
		tgt_stbd = PULSE_MID;
		app_port = PULSE_MID;
		app_vert = PULSE_MID;
		app_stbd = PULSE_MID;
		thr_pct = 0;
		yaw_pct = 0;
		none = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_registers();

		// directed items at reset settings
		foreach (directed_steps[i]) begin
			row = directed_steps[i];
			c = '{row.mode, row.a1, row.a2, row.a3};
			typed_r = '{row.e_port, row.e_vert, row.e_stbd, row.e_chg, row.e_thr, row.e_acc};
			issue_command(c, row.typed, typed_r);
		end
		drain_readouts();

		// random phases: sender-light, receiver-light, then no idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					tx_idle_pct = 38;
					rx_idle_pct = 85;
				end
				1: begin
					tx_idle_pct = 85;
					rx_idle_pct = 38;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			program_mixer(fwd_settings[ph], rev_settings[ph], mid_settings[ph]);
			for (int k = 0; k < 330; k++) begin
				issue_command(draw_command(), 1'b0, none);
				// occasional hold-off until the pipeline is empty
				if ($urandom_range(149) == 0)
					drain_readouts();
			end
			drain_readouts();
		end

		repeat (50) @(posedge clk);
		if (err_count == 0 && readout_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
